// File: src/dsdft_pkg.sv
// shared types, constants and twiddle tables for the damped sliding dft block
`default_nettype none
package dsdft_pkg;

  localparam int WINDOW_LENGTH = 64;
  localparam int NUM_BINS      = 32;
  localparam int SAMPLE_BITS   = 16;
  localparam int RING_AW       = 6;
  localparam int BIN_AW        = 5;
  localparam int TW_BITS       = 18;

  // action codes
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  localparam logic [BIN_AW-1:0] START_RESET = 5'd1;
  localparam logic [BIN_AW-1:0] END_RESET   = 5'd30;

  localparam longint R_Q28      = 268408612;
  localparam longint TWO_PI_Q28 = 1686629713;

  typedef logic signed [TW_BITS-1:0] tw_table_t [NUM_BINS];

  // truncating quotient of a non-negative value, by long division
  function automatic longint div_small(input longint num, input longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r << 1) | ((num >>> i) & longint'(1));
      if (r >= den) begin
        r = r - den;
        q = q | (longint'(1) << i);
      end
    end
    return q;
  endfunction

  // twiddle table, worked out at elaboration from a taylor series in q28
  function automatic tw_table_t make_tw_table(input bit imag);
    tw_table_t tab;
    longint p;
    longint th;
    longint term;
    longint c;
    longint s;
    longint x;
    bit neg;
    for (int k = 0; k < NUM_BINS; k++) begin
      p = k % WINDOW_LENGTH;
      neg = 1'b0;
      if (2 * p > WINDOW_LENGTH) begin
        p = WINDOW_LENGTH - p;
        neg = 1'b1;
      end
      th = (TWO_PI_Q28 * p + WINDOW_LENGTH / 2) / WINDOW_LENGTH;
      term = longint'(1) << 28;
      c = term;
      s = 0;
      for (int n = 1; n <= 24; n++) begin
        term = (term * th + (longint'(1) << 27)) >>> 28;
        term = div_small(term, longint'(n));
        case (n % 4)
          1: s = s + term;
          2: c = c - term;
          3: s = s - term;
          default: c = c + term;
        endcase
      end
      if (neg) s = -s;
      x = imag ? s : c;
      x = (R_Q28 * x + (longint'(1) << 38)) >>> 39;
      tab[k] = x[TW_BITS-1:0];
    end
    return tab;
  endfunction

  // damping of the oldest sample, r to the window length, in q17
  function automatic logic signed [TW_BITS-1:0] make_rpn_q17();
    longint p;
    p = longint'(1) << 28;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      p = (p * R_Q28 + (longint'(1) << 27)) >>> 28;
    end
    p = (p + (longint'(1) << 10)) >>> 11;
    return p[TW_BITS-1:0];
  endfunction

  localparam tw_table_t TW_RE = make_tw_table(1'b0);
  localparam tw_table_t TW_IM = make_tw_table(1'b1);
  localparam logic signed [TW_BITS-1:0] RPN_Q17 = make_rpn_q17();

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_P_RD, S_P_MUL, S_P_DEL,
    S_B_RD, S_B_DAT, S_B_M1, S_B_M2, S_B_WR,
    S_R_RD, S_R_DAT, S_SQ, S_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic               load_item;
    logic               ring_rd;
    logic               delta_mul;
    logic               delta_calc;
    logic               clr_wr;
    logic               bin_rd;
    logic               bin_latch;
    logic               bin_mul1;
    logic               bin_mul2;
    logic               bin_wr;
    logic               win_shift;
    logic               sq_en;
    logic [2:0]         sq_step;
    logic               emit;
    logic               emit_last;
    logic [BIN_AW-1:0]  idx;
    logic [RING_AW-1:0] clr_addr;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: src/dsdft_ram.sv
// generic single write port ram with registered read
`default_nettype none
module dsdft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: src/dsdft_ctrl.sv
// controller: configuration registers, range setup and sequencing fsm
`default_nettype none
module dsdft_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [1:0]                action,
  input  wire logic                      cfg_write,
  input  wire logic                      cfg_index,
  input  wire logic [dsdft_pkg::BIN_AW-1:0] cfg_data,
  input  wire dsdft_pkg::dp_stat_t       stat,
  output      dsdft_pkg::dp_cmd_t        cmd
);

  localparam int AW = dsdft_pkg::BIN_AW;

  dsdft_pkg::state_t state, state_next;
  logic [AW-1:0] idx, idx_next;
  logic [2:0] step, step_next;
  logic [dsdft_pkg::RING_AW-1:0] clr_cnt, clr_next;
  logic [AW-1:0] lo, lo_next, hi, hi_next;
  logic [AW-1:0] start_req, end_req;
  logic [AW-1:0] lo_c, hi_c;
  logic [AW:0] b_ext;
  logic narrow;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_req <= dsdft_pkg::START_RESET;
      end_req <= dsdft_pkg::END_RESET;
    end else if (cfg_write) begin
      if (cfg_index == dsdft_pkg::REG_START) start_req <= cfg_data;
      if (cfg_index == dsdft_pkg::REG_END) end_req <= cfg_data;
    end
  end

  // active range, widened by one bin on each side and clamped
  always_comb begin
    lo_c = (start_req == '0) ? '0 : start_req - 1'b1;
    b_ext = {1'b0, end_req} + 1'b1;
    if (b_ext < {1'b0, lo_c}) b_ext = {1'b0, lo_c};
    if (b_ext > (AW+1)'(dsdft_pkg::NUM_BINS - 1)) b_ext = (AW+1)'(dsdft_pkg::NUM_BINS - 1);
    hi_c = b_ext[AW-1:0];
    narrow = ({1'b0, hi_c} < ({1'b0, lo_c} + (AW+1)'(2)));
  end

  assign in_stall = (state != dsdft_pkg::S_IDLE);

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsdft_pkg::S_CLR;
      clr_cnt <= '0;
      idx <= '0;
      step <= '0;
      lo <= '0;
      hi <= '0;
    end else begin
      state <= state_next;
      clr_cnt <= clr_next;
      idx <= idx_next;
      step <= step_next;
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    idx_next = idx;
    step_next = step;
    clr_next = clr_cnt;
    lo_next = lo;
    hi_next = hi;
    cmd = '0;
    cmd.idx = idx;
    cmd.clr_addr = clr_cnt;
    cmd.sq_step = step;
    cmd.emit_last = (idx == hi);
    case (state)
      dsdft_pkg::S_CLR: begin
        cmd.clr_wr = 1'b1;
        clr_next = clr_cnt + 1'b1;
        if (clr_cnt == dsdft_pkg::RING_AW'(dsdft_pkg::WINDOW_LENGTH - 1)) begin
          state_next = dsdft_pkg::S_IDLE;
        end
      end
      dsdft_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          lo_next = lo_c;
          hi_next = hi_c;
          case (action)
            dsdft_pkg::ACT_PUSH: begin
              state_next = dsdft_pkg::S_P_RD;
            end
            dsdft_pkg::ACT_READ: begin
              if (!narrow) begin
                idx_next = lo_c;
                state_next = dsdft_pkg::S_R_RD;
              end
            end
            dsdft_pkg::ACT_CLEAR: begin
              clr_next = '0;
              state_next = dsdft_pkg::S_CLR;
            end
            default: ;
          endcase
        end
      end
      dsdft_pkg::S_P_RD: begin
        cmd.ring_rd = 1'b1;
        state_next = dsdft_pkg::S_P_MUL;
      end
      dsdft_pkg::S_P_MUL: begin
        cmd.delta_mul = 1'b1;
        state_next = dsdft_pkg::S_P_DEL;
      end
      dsdft_pkg::S_P_DEL: begin
        cmd.delta_calc = 1'b1;
        idx_next = lo;
        state_next = dsdft_pkg::S_B_RD;
      end
      dsdft_pkg::S_B_RD: begin
        cmd.bin_rd = 1'b1;
        state_next = dsdft_pkg::S_B_DAT;
      end
      dsdft_pkg::S_B_DAT: begin
        cmd.bin_latch = 1'b1;
        state_next = dsdft_pkg::S_B_M1;
      end
      dsdft_pkg::S_B_M1: begin
        cmd.bin_mul1 = 1'b1;
        state_next = dsdft_pkg::S_B_M2;
      end
      dsdft_pkg::S_B_M2: begin
        cmd.bin_mul2 = 1'b1;
        state_next = dsdft_pkg::S_B_WR;
      end
      dsdft_pkg::S_B_WR: begin
        cmd.bin_wr = 1'b1;
        if (idx == hi) begin
          state_next = dsdft_pkg::S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
          state_next = dsdft_pkg::S_B_RD;
        end
      end
      dsdft_pkg::S_R_RD: begin
        cmd.bin_rd = 1'b1;
        state_next = dsdft_pkg::S_R_DAT;
      end
      dsdft_pkg::S_R_DAT: begin
        cmd.win_shift = 1'b1;
        if ({1'b0, idx} >= ({1'b0, lo} + (AW+1)'(2))) begin
          step_next = '0;
          state_next = dsdft_pkg::S_SQ;
        end else begin
          idx_next = idx + 1'b1;
          state_next = dsdft_pkg::S_R_RD;
        end
      end
      dsdft_pkg::S_SQ: begin
        cmd.sq_en = 1'b1;
        step_next = step + 1'b1;
        if (step == 3'd5) state_next = dsdft_pkg::S_EMIT;
      end
      dsdft_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (idx == hi) begin
            state_next = dsdft_pkg::S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            state_next = dsdft_pkg::S_R_RD;
          end
        end
      end
      default: state_next = dsdft_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: src/dsdft_dp.sv
// datapath: sample ring, bin memory, complex update, windowed power, output register
`default_nettype none
module dsdft_dp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dsdft_pkg::dp_cmd_t       cmd,
  output      dsdft_pkg::dp_stat_t      stat,
  input  wire logic signed [dsdft_pkg::SAMPLE_BITS-1:0] sample,
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic [dsdft_pkg::BIN_AW-1:0] bin_index,
  output      logic [47:0]              power,
  output      logic                     last
);

  localparam int SB = dsdft_pkg::SAMPLE_BITS;
  localparam int RA = dsdft_pkg::RING_AW;
  localparam int BA = dsdft_pkg::BIN_AW;

  // round half up by 2^17 and saturate to 32 bits
  function automatic logic signed [31:0] rnd_sat(input logic signed [52:0] x);
    logic signed [52:0] y;
    y = (x + 53'sd65536) >>> 17;
    if (y > 53'sd2147483647) return 32'sh7fffffff;
    else if (y < -53'sd2147483648) return 32'sh80000000;
    else return y[31:0];
  endfunction

  logic signed [SB-1:0] smp;
  logic [RA-1:0] pos;
  logic [SB-1:0] ring_rd_data;
  logic ring_wr;
  logic [RA-1:0] ring_wr_addr;
  logic [SB-1:0] ring_wr_data;
  logic [63:0] bin_rd_data;
  logic bin_wr_en;
  logic [BA-1:0] bin_wr_addr;
  logic [63:0] bin_wr_data;
  logic signed [31:0] rd_re, rd_im;
  logic signed [33:0] prod_d;
  logic signed [25:0] delta;
  logic signed [33:0] a, b;
  logic signed [51:0] p1, p2;
  logic signed [31:0] nre;
  logic signed [31:0] nim;
  logic signed [dsdft_pkg::TW_BITS-1:0] tw_r, tw_i;
  logic signed [31:0] x0r, x1r, x2r, x0i, x1i, x2i;
  logic signed [34:0] v2r, v2i;
  logic [33:0] mr, mi, mv;
  logic [16:0] opa, opb;
  logic [33:0] sq_prod;
  logic [68:0] sq_term;
  logic [68:0] acc;
  logic [47:0] pwr;

  assign rd_re = bin_rd_data[63:32];
  assign rd_im = bin_rd_data[31:0];
  assign tw_r = dsdft_pkg::TW_RE[cmd.idx];
  assign tw_i = dsdft_pkg::TW_IM[cmd.idx];
  assign nim = rnd_sat(53'(p1) + 53'(p2));

  // ring write: clearing pass or new sample
  assign ring_wr = cmd.clr_wr | cmd.delta_calc;
  assign ring_wr_addr = cmd.clr_wr ? cmd.clr_addr : pos;
  assign ring_wr_data = cmd.clr_wr ? '0 : smp;

  // bin write: clearing pass over the lower addresses or updated bin
  assign bin_wr_en = (cmd.clr_wr & ~cmd.clr_addr[RA-1]) | cmd.bin_wr;
  assign bin_wr_addr = cmd.clr_wr ? cmd.clr_addr[BA-1:0] : cmd.idx;
  assign bin_wr_data = cmd.clr_wr ? '0 : {nre, nim};

  dsdft_ram #(.WIDTH(SB), .DEPTH(dsdft_pkg::WINDOW_LENGTH)) u_ring (
    .clk(clk), .wr_en(ring_wr), .wr_addr(ring_wr_addr), .wr_data(ring_wr_data),
    .rd_en(cmd.ring_rd), .rd_addr(pos), .rd_data(ring_rd_data)
  );

  dsdft_ram #(.WIDTH(64), .DEPTH(dsdft_pkg::NUM_BINS)) u_bins (
    .clk(clk), .wr_en(bin_wr_en), .wr_addr(bin_wr_addr), .wr_data(bin_wr_data),
    .rd_en(cmd.bin_rd), .rd_addr(cmd.idx), .rd_data(bin_rd_data)
  );

  // ring position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.clr_wr) begin
      pos <= '0;
    end else if (cmd.delta_calc) begin
      pos <= pos + 1'b1;
    end
  end

  // sample latch, damped oldest sample and delta
  always_ff @(posedge clk) begin
    if (cmd.load_item) smp <= sample;
    if (cmd.delta_mul) prod_d <= 34'(dsdft_pkg::RPN_Q17 * $signed(ring_rd_data));
    if (cmd.delta_calc) begin
      delta <= (26'(smp) <<< 8) - 26'((prod_d + 34'sd256) >>> 9);
    end
  end

  // complex twiddle update of one bin
  always_ff @(posedge clk) begin
    if (cmd.bin_latch) begin
      a <= 34'(rd_re) + 34'(delta);
      b <= 34'(rd_im);
    end
    if (cmd.bin_mul1) begin
      p1 <= 52'(tw_r * a);
      p2 <= 52'(tw_i * b);
    end
    if (cmd.bin_mul2) begin
      nre <= rnd_sat(53'(p1) - 53'(p2));
      p1 <= 52'(tw_r * b);
      p2 <= 52'(tw_i * a);
    end
  end

  // three-bin window for the hann kernel
  always_ff @(posedge clk) begin
    if (cmd.win_shift) begin
      x0r <= x1r;
      x1r <= x2r;
      x2r <= rd_re;
      x0i <= x1i;
      x1i <= x2i;
      x2i <= rd_im;
    end
  end

  assign v2r = 35'(x1r) + 35'(x1r) - 35'(x0r) - 35'(x2r);
  assign v2i = 35'(x1i) + 35'(x1i) - 35'(x0i) - 35'(x2i);
  assign mr = v2r[34] ? 34'(-v2r) : 34'(v2r);
  assign mi = v2i[34] ? 34'(-v2i) : 34'(v2i);
  assign mv = (cmd.sq_step < 3'd3) ? mr : mi;

  // squares from 17x17 partial products, one per cycle
  always_comb begin
    case (cmd.sq_step)
      3'd0, 3'd3: begin
        opa = mv[33:17];
        opb = mv[33:17];
        sq_prod = opa * opb;
        sq_term = 69'(sq_prod) << 34;
      end
      3'd1, 3'd4: begin
        opa = mv[33:17];
        opb = mv[16:0];
        sq_prod = opa * opb;
        sq_term = 69'(sq_prod) << 18;
      end
      3'd2, 3'd5: begin
        opa = mv[16:0];
        opb = mv[16:0];
        sq_prod = opa * opb;
        sq_term = 69'(sq_prod);
      end
      default: begin
        opa = '0;
        opb = '0;
        sq_prod = '0;
        sq_term = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en) acc <= ((cmd.sq_step == 3'd0) ? 69'd0 : acc) + sq_term;
  end

  assign pwr = (|acc[68:66]) ? '1 : acc[65:18];

  // output register
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bin_index <= cmd.idx - 1'b1;
      power <= pwr;
      last <= cmd.emit_last;
    end
  end

endmodule
`default_nettype wire

// File: src/damped_sliding_dft_hann_power.sv
// push: damped delta, then one shared complex update per active bin, up to 32 bins
// read: bin fetches, then a 6-step squaring unit per result; output stalls hold it
// clear: one ring entry per cycle through the clearing pass, bins in its first half
// results leave through an output register; the next transaction waits for the current one
// reset: synchronous; runs the clearing pass, input stalled until it ends
// top level of the damped sliding dft with hann-windowed power readout
`default_nettype none
module damped_sliding_dft_hann_power (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  action,
  input  wire logic signed [15:0] sample,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [4:0]  bin_index,
  output      logic [47:0] power,
  output      logic        last,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);

  dsdft_pkg::dp_cmd_t cmd;
  dsdft_pkg::dp_stat_t stat;

  dsdft_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .stat(stat), .cmd(cmd)
  );

  dsdft_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .bin_index(bin_index),
    .power(power), .last(last)
  );

endmodule
`default_nettype wire

// File: src/dsdft_checker.sv
// port-level checker for the damped sliding dft block and its bind
`default_nettype none
module dsdft_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  action,
  input wire logic signed [15:0] sample,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [4:0]  bin_index,
  input wire logic [47:0] power,
  input wire logic        last,
  input wire logic        cfg_write,
  input wire logic        cfg_index,
  input wire logic [4:0]  cfg_data
);

  // clearing pass holds off input after reset
  a_rst_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // no result right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a push transaction keeps the block busy in the next cycle
  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && action == dsdft_pkg::ACT_PUSH) |=> in_stall)
    else $error("push did not occupy the block");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(power) && $stable(bin_index) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind damped_sliding_dft_hann_power dsdft_checker u_dsdft_checker (.*);
`default_nettype wire
